FILE: design/approx_min_enclosing_sphere_macros.svh
// Assertion macros shared by the sphere fitter.
// Each check samples on clk and is off while arst_n is low.
`ifndef APPROX_MIN_ENCLOSING_SPHERE_MACROS_SVH
`define APPROX_MIN_ENCLOSING_SPHERE_MACROS_SVH
`ifndef ASSERT_OFF
`define AMES_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("ames check failed");
`define AMES_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else $error("ames check failed");
`else
`define AMES_ASSERT(lbl, prop)
`define AMES_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/ames_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ames_pkg;

	// One input point with its end-of-set mark.
	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic               last_point;
	} point_t;

	// One fitted sphere.
	typedef struct packed {
		logic signed [23:0] centre_x;
		logic signed [23:0] centre_y;
		logic signed [23:0] centre_z;
		logic [24:0]        radius;
		logic               overflow_flag;
	} result_t;

	// Register indexes of the write port.
	localparam logic [1:0] REG_ROUND_COUNT  = 2'd0;
	localparam logic [1:0] REG_INITIAL_STEP = 2'd1;
	localparam logic [1:0] REG_STEP_DECAY   = 2'd2;

	localparam logic [19:0] ROUND_COUNT_RESET  = 20'd100000;
	localparam logic [16:0] INITIAL_STEP_RESET = 17'd65536;
	localparam logic [15:0] STEP_DECAY_RESET   = 16'd65470;

	// A step of one in Q1.16.
	localparam logic [16:0] STEP_ONE = 17'd65536;

	// Squared distance width and root width.
	localparam int DIST_W = 50;
	localparam int ROOT_W = 25;

endpackage
`default_nettype wire

FILE: design/ames_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module ames_isqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ames_pkg::DIST_W-1:0] value,
	output logic                           done,
	output logic [ames_pkg::ROOT_W-1:0]    root
);
	import ames_pkg::*;

	logic [DIST_W-1:0] v_q;
	logic [ROOT_W+2:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic [ROOT_W+2:0] rem_n;
	logic [ROOT_W+2:0] trial;

	// Bring down the next two bits and try the next root bit.
	assign rem_n = {rem_q[ROOT_W:0], v_q[DIST_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	// One root bit per cycle, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			v_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				v_q    <= value;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 5'(ROOT_W - 1);
			end else if (run_q) begin
				v_q <= {v_q[DIST_W-3:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

FILE: design/approx_min_enclosing_sphere.sv
`timescale 1ns / 1ps
`default_nettype none
// Approximate minimum enclosing sphere. Points load one per cycle while busy is low; a
// point with last_point set starts the fit and raises busy. Each round scans every stored
// point through the states RD, SQX, SQY, SQZ and CMP with one shared multiplier, then
// moves the centre and decays the step in MVX, MVY, MVZ, DECM and DEC (only DECM and DEC
// when no point lies beyond distance zero), and the final round is followed by a square
// root. The fit ends early once the step reaches zero. The result appears for one cycle
// with done high and cannot be held off, so it must be captured then. The point memory
// needs no clearing after reset.
module approx_min_enclosing_sphere #(
	parameter int MAX_POINTS = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire ames_pkg::point_t point,
	output logic                  done,
	output ames_pkg::result_t     result,
	input  wire logic             wr_en,
	input  wire logic [1:0]       wr_index,
	input  wire logic [19:0]      wr_data
);
	import ames_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_SQX, ST_SQY, ST_SQZ, ST_CMP,
		ST_MVX, ST_MVY, ST_MVZ, ST_DECM, ST_DEC, ST_SQRT
	} state_t;

	state_t state_q;

	logic [19:0] round_count_q;
	logic [16:0] initial_step_q;
	logic [15:0] step_decay_q;

	logic signed [23:0] mem_x [MAX_POINTS];
	logic signed [23:0] mem_y [MAX_POINTS];
	logic signed [23:0] mem_z [MAX_POINTS];
	logic signed [23:0] rx_q, ry_q, rz_q;

	logic [CW-1:0]       cnt_q;
	logic                dropped_q;
	logic [AW-1:0]       idx_q;
	logic [19:0]         round_q;
	logic [16:0]         step_q;
	logic signed [23:0]  cx_q, cy_q, cz_q;
	logic signed [23:0]  bx_q, by_q, bz_q;
	logic [DIST_W-1:0]   best_q;
	logic [DIST_W-1:0]   acc_q;
	logic                found_q;
	logic                move_q;
	logic signed [51:0]  prod_q;
	logic                done_q;
	result_t             result_q;

	logic                accept;
	logic                store_en;
	logic signed [25:0]  mul_a, mul_b;
	logic [DIST_W-1:0]   dsum;
	logic                upd;
	logic                last_idx;
	logic signed [51:0]  rnd;
	logic signed [23:0]  mv;
	logic                sqrt_start;
	logic                sqrt_go;
	logic [DIST_W-1:0]   sqrt_value;
	logic                sqrt_done;
	logic [ROOT_W-1:0]   sqrt_root;

	assign accept   = start && !busy;
	assign store_en = accept && (cnt_q < CW'(MAX_POINTS));
	assign busy     = (state_q != ST_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q  <= ROUND_COUNT_RESET;
			initial_step_q <= INITIAL_STEP_RESET;
			step_decay_q   <= STEP_DECAY_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROUND_COUNT:  round_count_q  <= wr_data;
				REG_INITIAL_STEP: initial_step_q <= wr_data[16:0];
				REG_STEP_DECAY:   step_decay_q   <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Point memory: written while loading, read with a registered port while fitting.
	always_ff @(posedge clk) begin
		if (store_en) begin
			mem_x[cnt_q[AW-1:0]] <= point.point_x;
			mem_y[cnt_q[AW-1:0]] <= point.point_y;
			mem_z[cnt_q[AW-1:0]] <= point.point_z;
		end
		rx_q <= mem_x[idx_q];
		ry_q <= mem_y[idx_q];
		rz_q <= mem_z[idx_q];
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = 26'(rx_q) - 26'(cx_q);
				mul_b = mul_a;
			end
			ST_SQY: begin
				mul_a = 26'(ry_q) - 26'(cy_q);
				mul_b = mul_a;
			end
			ST_SQZ: begin
				mul_a = 26'(rz_q) - 26'(cz_q);
				mul_b = mul_a;
			end
			ST_MVX: begin
				mul_a = 26'(bx_q) - 26'(cx_q);
				mul_b = $signed({9'd0, step_q});
			end
			ST_MVY: begin
				mul_a = 26'(by_q) - 26'(cy_q);
				mul_b = $signed({9'd0, step_q});
			end
			ST_MVZ: begin
				mul_a = 26'(bz_q) - 26'(cz_q);
				mul_b = $signed({9'd0, step_q});
			end
			ST_DECM: begin
				mul_a = $signed({9'd0, step_q});
				mul_b = $signed({10'd0, step_decay_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Distance compare and rounded centre move.
	assign dsum     = acc_q + prod_q[DIST_W-1:0];
	assign upd      = dsum > best_q;
	assign last_idx = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign rnd      = prod_q + 52'sd32768;
	assign mv       = rnd[39:16];

	assign sqrt_start = (state_q == ST_CMP) && last_idx
		&& ((step_q == '0) || (round_q == round_count_q - 20'd1));

	// The root starts with the last compare of the final round, or at once for zero rounds.
	// That last compare may still raise the best distance in the cycle the root starts.
	assign sqrt_go    = sqrt_start || ((state_q == ST_IDLE) && accept && point.last_point
		&& (round_count_q == '0));
	assign sqrt_value = (state_q == ST_IDLE) ? '0 : (upd ? dsum : best_q);

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			idx_q     <= '0;
			round_q   <= '0;
			step_q    <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			cz_q      <= '0;
			bx_q      <= '0;
			by_q      <= '0;
			bz_q      <= '0;
			best_q    <= '0;
			acc_q     <= '0;
			found_q   <= 1'b0;
			move_q    <= 1'b0;
			prod_q    <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q <= 1'b0;
			prod_q <= mul_a * mul_b;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (store_en) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (point.last_point) begin
							cx_q    <= '0;
							cy_q    <= '0;
							cz_q    <= '0;
							best_q  <= '0;
							found_q <= 1'b0;
							idx_q   <= '0;
							round_q <= '0;
							step_q  <= (initial_step_q > STEP_ONE) ? STEP_ONE
								: initial_step_q;
							state_q <= (round_count_q == '0) ? ST_SQRT : ST_RD;
						end
					end
				end
				ST_RD:  state_q <= ST_SQX;
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: begin
					acc_q   <= prod_q[DIST_W-1:0];
					state_q <= ST_SQZ;
				end
				ST_SQZ: begin
					acc_q   <= dsum;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (upd) begin
						best_q  <= dsum;
						found_q <= 1'b1;
						bx_q    <= rx_q;
						by_q    <= ry_q;
						bz_q    <= rz_q;
					end
					if (!last_idx) begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_RD;
					end else if (sqrt_start) begin
						state_q <= ST_SQRT;
					end else begin
						move_q  <= found_q || upd;
						state_q <= (found_q || upd) ? ST_MVX : ST_DECM;
					end
				end
				ST_MVX: state_q <= ST_MVY;
				ST_MVY: begin
					cx_q    <= cx_q + mv;
					state_q <= ST_MVZ;
				end
				ST_MVZ: begin
					cy_q    <= cy_q + mv;
					state_q <= ST_DECM;
				end
				ST_DECM: begin
					if (move_q) begin
						cz_q <= cz_q + mv;
					end
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					step_q  <= prod_q[32:16];
					round_q <= round_q + 20'd1;
					best_q  <= '0;
					found_q <= 1'b0;
					idx_q   <= '0;
					state_q <= ST_RD;
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						result_q.centre_x      <= cx_q;
						result_q.centre_y      <= cy_q;
						result_q.centre_z      <= cz_q;
						result_q.radius        <= sqrt_root;
						result_q.overflow_flag <= dropped_q;
						done_q    <= 1'b1;
						cnt_q     <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Square root of the final largest squared distance.
	ames_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_go),
		.value  (sqrt_value),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign done   = done_q;
	assign result = result_q;

	`include "approx_min_enclosing_sphere_macros.svh"

	`AMES_ASSERT_NEXT(a_root_to_result, (state_q == ST_SQRT) && sqrt_done, done && !busy)
	`AMES_ASSERT(a_done_idle, done |-> !busy)
	`AMES_ASSERT_NEXT(a_last_starts, accept && point.last_point, busy)
	`AMES_ASSERT(a_count_bound, cnt_q <= CW'(MAX_POINTS))

endmodule
`default_nettype wire

FILE: tb/sv/sphere_checker.sv
`timescale 1ns / 1ps
module sphere_checker #(
	parameter int MAX_POINTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  ames_pkg::point_t  point,
	input  logic              done,
	input  ames_pkg::result_t result,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [19:0]       wr_data,
	output int                fail_count,
	output int                pending
);
	import ames_pkg::*;

	// Shadow copy of the point memory and the set bookkeeping.
	longint    pts_x [MAX_POINTS];
	longint    pts_y [MAX_POINTS];
	longint    pts_z [MAX_POINTS];
	int        point_total;
	bit        points_dropped;
	logic [19:0] rounds_cfg;
	logic [16:0] step_cfg;
	logic [15:0] decay_cfg;
	result_t   sphere_q[$];

	// Floor square root, one result bit per pass.
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned res;
		longint unsigned bitpos;
		res = 0;
		bitpos = 64'd1 << 62;
		while (bitpos > v) bitpos >>= 2;
		while (bitpos != 0) begin
			if (v >= res + bitpos) begin
				v -= res + bitpos;
				res = (res >> 1) + bitpos;
			end else begin
				res >>= 1;
			end
			bitpos >>= 2;
		end
		return res;
	endfunction

	// Largest squared distance from the centre; the first point reaching it wins ties.
	function automatic longint unsigned farthest_sq(input longint cx, input longint cy,
			input longint cz, output int idx, output bit found);
		longint unsigned best;
		longint unsigned d2;
		longint dx, dy, dz;
		best = 0;
		idx = 0;
		found = 1'b0;
		for (int i = 0; i < point_total; i++) begin
			dx = pts_x[i] - cx;
			dy = pts_y[i] - cy;
			dz = pts_z[i] - cz;
			d2 = dx * dx + dy * dy + dz * dz;
			if (d2 > best) begin
				best = d2;
				idx = i;
				found = 1'b1;
			end
		end
		return best;
	endfunction

	// Step fraction applied to one axis difference, rounded half up.
	function automatic longint step_toward(input longint d, input longint step);
		return (d * step + 32768) >>> 16;
	endfunction

	// Runs the refinement rounds over the current set and builds the sphere.
	function automatic result_t fit_sphere();
		result_t s;
		longint cx, cy, cz;
		longint step;
		longint unsigned maxd;
		int idx;
		bit found;
		cx = 0;
		cy = 0;
		cz = 0;
		maxd = 0;
		step = (step_cfg > STEP_ONE) ? 65536 : longint'(step_cfg);
		for (longint r = 0; r < rounds_cfg; r++) begin
			maxd = farthest_sq(cx, cy, cz, idx, found);
			// A zero step freezes the centre, so later rounds change nothing.
			if (step == 0) break;
			if (r != rounds_cfg - 1 && found) begin
				cx += step_toward(pts_x[idx] - cx, step);
				cy += step_toward(pts_y[idx] - cy, step);
				cz += step_toward(pts_z[idx] - cz, step);
			end
			step = (step * decay_cfg) >> 16;
		end
		s.centre_x = cx[23:0];
		s.centre_y = cy[23:0];
		s.centre_z = cz[23:0];
		s.radius = 25'(floor_root(maxd));
		s.overflow_flag = points_dropped;
		return s;
	endfunction

	function automatic void check_field(input string name, input longint expv,
			input longint actv);
		if (expv != actv) begin
			$display("%0t: %s expected %0d actual %0d", $realtime, name, expv, actv);
			fail_count++;
		end
	endfunction

	// Mirror register writes, store accepted points, compare each finished fit.
	always @(posedge clk or negedge arst_n) begin
		result_t exp_s;
		if (!arst_n) begin
			rounds_cfg = ROUND_COUNT_RESET;
			step_cfg = INITIAL_STEP_RESET;
			decay_cfg = STEP_DECAY_RESET;
			point_total = 0;
			points_dropped = 1'b0;
			sphere_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (sphere_q.size() == 0) begin
					$display("%0t: unexpected result transaction, actual %p", $realtime,
						result);
					fail_count++;
				end else begin
					exp_s = sphere_q.pop_front();
					check_field("centre_x", exp_s.centre_x, result.centre_x);
					check_field("centre_y", exp_s.centre_y, result.centre_y);
					check_field("centre_z", exp_s.centre_z, result.centre_z);
					check_field("radius", exp_s.radius, result.radius);
					check_field("overflow_flag", exp_s.overflow_flag, result.overflow_flag);
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_ROUND_COUNT: rounds_cfg = wr_data[19:0];
					REG_INITIAL_STEP: step_cfg = wr_data[16:0];
					REG_STEP_DECAY: decay_cfg = wr_data[15:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (point_total < MAX_POINTS) begin
					pts_x[point_total] = point.point_x;
					pts_y[point_total] = point.point_y;
					pts_z[point_total] = point.point_z;
					point_total++;
				end else begin
					points_dropped = 1'b1;
				end
				if (point.last_point) begin
					sphere_q = {sphere_q, fit_sphere()};
					point_total = 0;
					points_dropped = 1'b0;
				end
			end
			pending = sphere_q.size();
		end
	end
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import ames_pkg::*;

	localparam int IDLE_LIMIT = 100000;
	localparam int POINT_GOAL = 1900;
	localparam int MAX_POINTS_TB = 1024;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	point_t      point = '0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = REG_ROUND_COUNT;
	logic [19:0] wr_data = '0;
	logic        busy;
	logic        done;
	result_t     result;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          points_sent = 0;
	int          sets_sent = 0;
	int          config_phases = 0;

	approx_min_enclosing_sphere uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	sphere_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watchdog: stop if no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Offers one point and holds it until the block takes it; bursts end in a gap.
	task automatic send_point(input point_t p);
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy);
		points_sent++;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	// Waits until the block is idle and every fit has been reported.
	task automatic wait_idle();
		if (start) start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(input logic [19:0] rounds, input logic [16:0] step,
			input logic [15:0] decay);
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= REG_ROUND_COUNT;
		wr_data <= rounds;
		@(posedge clk);
		wr_index <= REG_INITIAL_STEP;
		wr_data <= {3'b000, step};
		@(posedge clk);
		wr_index <= REG_STEP_DECAY;
		wr_data <= {4'b0000, decay};
		@(posedge clk);
		wr_en <= 1'b0;
		config_phases++;
	endtask

	// Coordinates: full range, a tiny cube that forces ties, or the extremes.
	function automatic logic [23:0] pick_coord(input int flavor);
		case (flavor)
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 6)) - 3);
			default: begin
				case ($urandom_range(0, 3))
					0: return 24'h800000;
					1: return 24'h7fffff;
					2: return 24'h000000;
					default: return 24'hffffff;
				endcase
			end
		endcase
	endfunction

	task automatic send_set(input int count, input int flavor);
		point_t p;
		for (int i = 0; i < count; i++) begin
			p.point_x = pick_coord(flavor);
			p.point_y = pick_coord(flavor);
			p.point_z = pick_coord(flavor);
			p.last_point = (i == count - 1);
			send_point(p);
		end
		sets_sent++;
	endtask

	task automatic send_one(input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] z);
		send_point('{point_x: x, point_y: y, point_z: z, last_point: 1'b1});
		sets_sent++;
	endtask

	initial begin
		logic [19:0] rounds;
		logic [16:0] step;
		logic [15:0] decay;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets: extremes, a zero-distance set, ties and odd register values.
		set_config(20'd4, STEP_ONE, 16'd32768);
		send_one(24'h7fffff, 24'h7fffff, 24'h7fffff);
		send_one(24'h800000, 24'h800000, 24'h800000);
		send_point('{point_x: 24'h800000, point_y: 24'h7fffff, point_z: 24'h800000,
			last_point: 1'b0});
		send_one(24'h7fffff, 24'h800000, 24'h7fffff);
		send_one(24'h0, 24'h0, 24'h0);
		send_set(3, 1);
		set_config(20'd0, 17'h1ffff, 16'd65535);
		send_set(2, 0);
		set_config(20'hfffff, 17'h1ffff, 16'd0);
		send_set(3, 2);
		set_config(20'd5, 17'd0, 16'd40000);
		send_set(2, 0);
		set_config(20'd1, STEP_ONE, 16'hffff);
		send_set(2, 0);

		// A set that runs past capacity; the dropped point still closes the set.
		set_config(20'd2, STEP_ONE, 16'd30000);
		send_set(MAX_POINTS_TB + 1, 0);

		// Random sets with occasional reconfiguration between phases.
		while (points_sent < POINT_GOAL) begin
			if (sets_sent % 30 == 0) begin
				decay = 16'($urandom);
				case ($urandom_range(0, 3))
					0: rounds = 20'($urandom_range(1, 3));
					1: rounds = 20'($urandom_range(4, 20));
					2: begin
						rounds = 20'hfffff;
						decay = 16'($urandom_range(0, 32768));
					end
					default: rounds = 20'($urandom_range(0, 1));
				endcase
				step = ($urandom_range(0, 2) == 0) ? 17'($urandom) : STEP_ONE;
				set_config(rounds, step, decay);
			end
			send_set(($urandom_range(0, 4) == 0) ? $urandom_range(8, 14)
				: $urandom_range(1, 6), $urandom_range(0, 2));
		end

		// Drain every outstanding fit, then a short settle.
		if (start) start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d points in %0d sets over %0d register settings,", points_sent,
			sets_sent, config_phases);
		$display("including extreme coordinates, tied points and a capacity overrun.");
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
